[rtl/core/kkm_pkg.sv]
// Shared widths, codes and types of the k-way k-mer merge block.
package kkm_pkg;

   localparam int KMER_W   = 62;
   localparam int COUNT_W  = 31;
   localparam int STREAM_W = 3;
   localparam int MASK_W   = 8;
   localparam int CSR_W    = 4;
   localparam int CNT_W    = 4;
   localparam int MAX_LANES = 8;

   localparam logic KIND_HEAD = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic REG_MIN_STREAMS  = 1'b0;
   localparam logic REG_STREAM_COUNT = 1'b1;

   typedef struct packed {
      logic clear;
      logic valid;
      logic present;
   } scan_ctl_type;

endpackage

[rtl/core/kkm_head_store.sv]
// Head record store: one k-mer and one abundance per stream, one write and one read port.
module kkm_head_store #(
   parameter int LANES = 8,
   parameter int KW    = 62
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [$clog2(LANES)-1:0]    wr_addr,
   input  logic [KW-1:0]               wr_kmer,
   input  logic [kkm_pkg::COUNT_W-1:0] wr_count,
   input  logic [$clog2(LANES)-1:0]    rd_addr,
   output logic [KW-1:0]               rd_kmer,
   output logic [kkm_pkg::COUNT_W-1:0] rd_count
);
   import kkm_pkg::*;

   logic [KW-1:0]      kmer_mem_ff  [LANES];
   logic [COUNT_W-1:0] count_mem_ff [LANES];
   logic [KW-1:0]      rd_kmer_ff;
   logic [COUNT_W-1:0] rd_count_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         kmer_mem_ff[wr_addr]  <= wr_kmer;
         count_mem_ff[wr_addr] <= wr_count;
      end
      rd_kmer_ff  <= kmer_mem_ff[rd_addr];
      rd_count_ff <= count_mem_ff[rd_addr];
   end

   assign rd_kmer  = rd_kmer_ff;
   assign rd_count = rd_count_ff;

endmodule

[rtl/core/kkm_min_unit.sv]
// Shared comparator that folds one stream head a cycle into the running minimum, mask and count.
module kkm_min_unit #(
   parameter int LANES = 8,
   parameter int KW    = 62
) (
   input  logic                      clock,
   input  logic                      reset,
   input  kkm_pkg::scan_ctl_type     ctl,
   input  logic [LANES-1:0]          lane_onehot,
   input  logic [KW-1:0]             kmer,
   output logic [KW-1:0]             low_kmer,
   output logic [LANES-1:0]          mask,
   output logic [kkm_pkg::CNT_W-1:0] count
);
   import kkm_pkg::*;

   logic              have_ff, have_in;
   logic [KW-1:0]     min_ff, min_in;
   logic [LANES-1:0]  mask_ff, mask_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;

   always_comb begin
      have_in = have_ff;
      min_in  = min_ff;
      mask_in = mask_ff;
      cnt_in  = cnt_ff;
      if (ctl.clear) begin
         have_in = 1'b0;
         mask_in = '0;
         cnt_in  = '0;
      end else if (ctl.valid && ctl.present) begin
         if (!have_ff || kmer < min_ff) begin
            have_in = 1'b1;
            min_in  = kmer;
            mask_in = lane_onehot;
            cnt_in  = CNT_W'(1);
         end else if (kmer == min_ff) begin
            mask_in = mask_ff | lane_onehot;
            cnt_in  = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
         mask_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         have_ff <= have_in;
         mask_ff <= mask_in;
         cnt_ff  <= cnt_in;
      end
      min_ff <= min_in;
   end

   assign low_kmer = min_ff;
   assign mask     = mask_ff;
   assign count    = cnt_ff;

endmodule

[rtl/core/kway_kmer_merge_threshold_top.sv]
// Top level of the k-way k-mer merge with abundance threshold and its sequencer.
//
//   Channel   Direction   Handshake              Word
//   req_      in          req_valid / req_ready  kind, stream, kmer, abundance
//   rsp_      out         rsp_valid / rsp_ready  kmer_out .. last
//   csr_      in          csr_wr_en              index, wdata
//
// A word that triggers no selection is taken and leaves the sequencer ready for the next word.
// A selection scans the active streams one per cycle through the single comparator and the
// single read port of the head store, then decides: a kept result gives a word per active
// stream (ST_EMIT_RD, ST_EMIT_WR), an unkept or done result a single word.
// Synchronous reset clears the control state and loads the register defaults; no clearing pass.
// A stalled result holds the sequencer; a new word is still taken while the last one waits.
module kway_kmer_merge_threshold_top #(
   parameter int NUM_STREAMS = 8,
   parameter int KMER_BASES  = 31
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_kind,
   input  logic [kkm_pkg::STREAM_W-1:0] req_stream,
   input  logic [kkm_pkg::KMER_W-1:0]   req_kmer,
   input  logic [kkm_pkg::COUNT_W-1:0]  req_abundance,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [kkm_pkg::KMER_W-1:0]   rsp_kmer_out,
   output logic [kkm_pkg::STREAM_W-1:0] rsp_stream_out,
   output logic [kkm_pkg::COUNT_W-1:0]  rsp_count_out,
   output logic                         rsp_kept,
   output logic [kkm_pkg::MASK_W-1:0]   rsp_refill_mask,
   output logic                         rsp_done_res,
   output logic                         rsp_last,
   input  logic                         csr_wr_en,
   input  logic                         csr_index,
   input  logic [kkm_pkg::CSR_W-1:0]    csr_wdata
);
   import kkm_pkg::*;

   localparam int LANES = (NUM_STREAMS < MAX_LANES) ? NUM_STREAMS : MAX_LANES;
   localparam int KW    = (KMER_BASES >= 31) ? KMER_W : 2 * KMER_BASES;
   localparam int AW    = $clog2(LANES);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_SCAN_END, ST_DECIDE,
      ST_EMIT_RD, ST_EMIT_WR, ST_EMIT_ONE, ST_EMIT_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [CSR_W-1:0]     min_streams_ff, min_streams_in;
   logic [CSR_W-1:0]     stream_count_ff, stream_count_in;
   logic [LANES-1:0]     present_ff, present_in;
   logic [LANES-1:0]     ended_ff, ended_in;
   logic                 finished_ff, finished_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic                 cmp_valid_ff, cmp_valid_in;
   logic [AW-1:0]        cmp_lane_ff, cmp_lane_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [KMER_W-1:0]    rsp_kmer_ff, rsp_kmer_in;
   logic [STREAM_W-1:0]  rsp_stream_ff, rsp_stream_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic                 rsp_kept_ff, rsp_kept_in;
   logic [MASK_W-1:0]    rsp_mask_ff, rsp_mask_in;
   logic                 rsp_done_ff, rsp_done_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [CSR_W-1:0]     active_n;
   logic [LANES-1:0]     active_mask;
   logic                 wr_en;
   logic [KW-1:0]        rd_kmer;
   logic [COUNT_W-1:0]   rd_count;
   scan_ctl_type         scan_ctl;
   logic [LANES-1:0]     cmp_onehot;
   logic [KW-1:0]        sel_kmer;
   logic [LANES-1:0]     min_mask;
   logic [CNT_W-1:0]     min_count;

   always_comb begin
      if (stream_count_ff == '0) begin
         active_n = CSR_W'(1);
      end else if (stream_count_ff > CSR_W'(LANES)) begin
         active_n = CSR_W'(LANES);
      end else begin
         active_n = stream_count_ff;
      end
      for (int i = 0; i < LANES; i++) begin
         active_mask[i] = (CSR_W'(i) < active_n);
      end
   end

   assign cmp_onehot = LANES'(1) << cmp_lane_ff;
   assign scan_ctl   = '{clear:   (state_ff == ST_IDLE),
                         valid:   cmp_valid_ff,
                         present: |(present_ff & cmp_onehot)};

   always_comb begin
      logic             accept;
      logic             ignore;
      logic [LANES-1:0] bit_s;
      logic [LANES-1:0] pres_new;
      logic [LANES-1:0] end_new;
      logic             out_free;
      logic             idx_last;
      logic             idx_hit;

      accept   = req_valid && (state_ff == ST_IDLE);
      bit_s    = LANES'(1) << req_stream;
      out_free = !rsp_valid_ff || rsp_ready;
      idx_last = (CSR_W'(idx_ff) == active_n - CSR_W'(1));
      idx_hit  = |(min_mask & (LANES'(1) << idx_ff));
      ignore   = finished_ff || !(CSR_W'(req_stream) < active_n)
                 || ((req_kind == KIND_HEAD) && ((ended_ff & bit_s) != '0));

      state_in        = state_ff;
      min_streams_in  = min_streams_ff;
      stream_count_in = stream_count_ff;
      present_in      = present_ff;
      ended_in        = ended_ff;
      finished_in     = finished_ff;
      idx_in          = idx_ff;
      cmp_valid_in    = 1'b0;
      cmp_lane_in     = idx_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_kmer_in     = rsp_kmer_ff;
      rsp_stream_in   = rsp_stream_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_kept_in     = rsp_kept_ff;
      rsp_mask_in     = rsp_mask_ff;
      rsp_done_in     = rsp_done_ff;
      rsp_last_in     = rsp_last_ff;
      wr_en           = accept && !ignore && (req_kind == KIND_HEAD);

      if (csr_wr_en) begin
         case (csr_index)
            REG_MIN_STREAMS:  min_streams_in  = csr_wdata;
            REG_STREAM_COUNT: stream_count_in = csr_wdata;
            default: ;
         endcase
      end

      if (req_kind == KIND_END) begin
         end_new  = ended_ff | bit_s;
         pres_new = present_ff & ~bit_s;
      end else begin
         end_new  = ended_ff;
         pres_new = present_ff | bit_s;
      end

      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
            if (accept && !ignore) begin
               present_in = pres_new;
               ended_in   = end_new;
               if (((pres_new | end_new) & active_mask) == active_mask) begin
                  if ((end_new & active_mask) == active_mask) begin
                     finished_in = 1'b1;
                     present_in  = '0;
                     state_in    = ST_EMIT_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            cmp_valid_in = 1'b1;
            idx_in       = idx_ff + AW'(1);
            if (idx_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            present_in = present_ff & ~min_mask;
            idx_in     = '0;
            if ({1'b0, min_count} >= {1'b0, min_streams_ff}) begin
               state_in = ST_EMIT_RD;
            end else begin
               state_in = ST_EMIT_ONE;
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_WR;
         end
         ST_EMIT_WR: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kmer_in   = KMER_W'(sel_kmer);
               rsp_stream_in = STREAM_W'(idx_ff);
               rsp_count_in  = idx_hit ? rd_count : '0;
               rsp_kept_in   = 1'b1;
               rsp_mask_in   = MASK_W'(min_mask);
               rsp_done_in   = 1'b0;
               rsp_last_in   = idx_last;
               idx_in        = idx_ff + AW'(1);
               state_in      = idx_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         ST_EMIT_ONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kmer_in   = KMER_W'(sel_kmer);
               rsp_stream_in = '0;
               rsp_count_in  = '0;
               rsp_kept_in   = 1'b0;
               rsp_mask_in   = MASK_W'(min_mask);
               rsp_done_in   = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_EMIT_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kmer_in   = '0;
               rsp_stream_in = '0;
               rsp_count_in  = '0;
               rsp_kept_in   = 1'b0;
               rsp_mask_in   = '0;
               rsp_done_in   = 1'b1;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         min_streams_ff  <= CSR_W'(3);
         stream_count_ff <= CSR_W'(8);
         present_ff      <= '0;
         ended_ff        <= '0;
         finished_ff     <= 1'b0;
         idx_ff          <= '0;
         cmp_valid_ff    <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         min_streams_ff  <= min_streams_in;
         stream_count_ff <= stream_count_in;
         present_ff      <= present_in;
         ended_ff        <= ended_in;
         finished_ff     <= finished_in;
         idx_ff          <= idx_in;
         cmp_valid_ff    <= cmp_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      cmp_lane_ff   <= cmp_lane_in;
      rsp_kmer_ff   <= rsp_kmer_in;
      rsp_stream_ff <= rsp_stream_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_kept_ff   <= rsp_kept_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_last_ff   <= rsp_last_in;
   end

   kkm_head_store #(
      .LANES (LANES),
      .KW    (KW)
   ) u_head_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (req_stream[AW-1:0]),
      .wr_kmer  (req_kmer[KW-1:0]),
      .wr_count (req_abundance),
      .rd_addr  (idx_ff),
      .rd_kmer  (rd_kmer),
      .rd_count (rd_count)
   );

   kkm_min_unit #(
      .LANES (LANES),
      .KW    (KW)
   ) u_min_unit (
      .clock       (clock),
      .reset       (reset),
      .ctl         (scan_ctl),
      .lane_onehot (cmp_onehot),
      .kmer        (rd_kmer),
      .low_kmer    (sel_kmer),
      .mask        (min_mask),
      .count       (min_count)
   );

   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kmer_out    = rsp_kmer_ff;
   assign rsp_stream_out  = rsp_stream_ff;
   assign rsp_count_out   = rsp_count_ff;
   assign rsp_kept        = rsp_kept_ff;
   assign rsp_refill_mask = rsp_mask_ff;
   assign rsp_done_res    = rsp_done_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
